@@ sv/framebuffer_beat_server_macros.svh @@
// assertion macros for the rtl, included by fbs_datapath
`ifndef FRAMEBUFFER_BEAT_SERVER_MACROS_SVH
`define FRAMEBUFFER_BEAT_SERVER_MACROS_SVH

`ifndef SYNTH
`define FBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fbs same-cycle check failed");
`define FBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fbs next-cycle check failed");
`else
`define FBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define FBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/fbs_pkg.sv @@
package fbs_pkg;

	localparam int unsigned STORE_BYTES = 262144;
	localparam int unsigned ADDR_W      = 24;
	localparam int unsigned CNT_W       = 32;
	localparam int unsigned DATA_W      = 16;

	// the store is split in an even-byte bank and an odd-byte bank
	localparam int unsigned EVEN_ROWS = (STORE_BYTES + 1) / 2;
	localparam int unsigned ODD_ROWS  = STORE_BYTES / 2;
	localparam int unsigned ROW_W     = (EVEN_ROWS > 1) ? $clog2(EVEN_ROWS) : 1;

	typedef enum logic [1:0] {
		OP_NOP   = 2'd0,
		OP_FETCH = 2'd1,
		OP_SET   = 2'd2,
		OP_DRAW  = 2'd3
	} opcode_t;

	typedef struct packed {
		logic clear;   // clearing pass writes one row
		logic ready;   // beat channel may take an item
		logic take;    // item accepted, issue bank reads
		logic commit;  // update state, load result register
	} fbs_cmd_t;

	typedef struct packed {
		logic clear_last;  // last row of the clearing pass
		logic out_free;    // result register can be loaded
	} fbs_sts_t;

	// both addr and addr+1 inside the store
	function automatic logic pair_ok(input logic [ADDR_W-1:0] addr);
		pair_ok = ((ADDR_W + 1)'(addr) + (ADDR_W + 1)'(1)) < (ADDR_W + 1)'(STORE_BYTES);
	endfunction

endpackage

@@ sv/fbs_if.sv @@
interface fbs_beat_if;
	import fbs_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          opcode;
	logic [ADDR_W-1:0]   payload;

	modport source (output valid, output opcode, output payload, input ready);
	modport sink   (input valid, input opcode, input payload, output ready);
endinterface

interface fbs_result_if;
	import fbs_pkg::*;
	logic                valid;
	logic                ready;
	logic                response_valid;
	logic [DATA_W-1:0]   read_data;
	logic [CNT_W-1:0]    fetch_total;
	logic [CNT_W-1:0]    set_total;
	logic [CNT_W-1:0]    draw_total;
	logic [CNT_W-1:0]    misalign_total;

	modport source (output valid, output response_valid, output read_data,
		output fetch_total, output set_total, output draw_total,
		output misalign_total, input ready);
	modport sink (input valid, input response_valid, input read_data,
		input fetch_total, input set_total, input draw_total,
		input misalign_total, output ready);
endinterface

@@ sv/framebuffer_beat_server.sv @@
// channel  | dir | handshake      | payload
// beat     | in  | valid / ready  | opcode (2), payload (24)
// result   | out | valid / ready  | response_valid, read_data (16), four 32-bit totals
//
// each item takes two steps: accept with the bank reads, then commit with the
// write and counter update; the registered reads of the single-ported banks set it
// after reset a clearing pass over all EVEN_ROWS rows (131072) loads every byte with
// its address low byte; no item is accepted during it
// a result waits in its register; the next item is accepted but commits only once
// the waiting result is taken
module framebuffer_beat_server (
	input  logic           clk,
	input  logic           arst_n,
	fbs_beat_if.sink       beat,
	fbs_result_if.source   result
);
	import fbs_pkg::*;

	fbs_cmd_t cmd;
	fbs_sts_t sts;

	// sequencer: clearing pass, accept, commit
	fbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (beat.valid),
		.sts        (sts),
		.cmd        (cmd)
	);

	// banks, pending set address, counters and the result register
	fbs_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.beat_opcode    (beat.opcode),
		.beat_payload   (beat.payload),
		.result_ready   (result.ready),
		.result_valid   (result.valid),
		.response_valid (result.response_valid),
		.read_data      (result.read_data),
		.fetch_total    (result.fetch_total),
		.set_total      (result.set_total),
		.draw_total     (result.draw_total),
		.misalign_total (result.misalign_total)
	);

	assign beat.ready = cmd.ready;

endmodule

@@ sv/fbs_ctrl.sv @@
module fbs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             beat_valid,
	input  fbs_pkg::fbs_sts_t sts,
	output fbs_pkg::fbs_cmd_t cmd
);
	import fbs_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (beat_valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_comb begin
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.ready  = (state_q == ST_IDLE);
		cmd.take   = (state_q == ST_IDLE) && beat_valid;
		cmd.commit = (state_q == ST_EXEC) && sts.out_free;
	end

endmodule

@@ sv/fbs_datapath.sv @@
`include "framebuffer_beat_server_macros.svh"

module fbs_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fbs_pkg::fbs_cmd_t          cmd,
	output fbs_pkg::fbs_sts_t          sts,
	input  logic [1:0]                 beat_opcode,
	input  logic [fbs_pkg::ADDR_W-1:0] beat_payload,
	input  logic                       result_ready,
	output logic                       result_valid,
	output logic                       response_valid,
	output logic [fbs_pkg::DATA_W-1:0] read_data,
	output logic [fbs_pkg::CNT_W-1:0]  fetch_total,
	output logic [fbs_pkg::CNT_W-1:0]  set_total,
	output logic [fbs_pkg::CNT_W-1:0]  draw_total,
	output logic [fbs_pkg::CNT_W-1:0]  misalign_total
);
	import fbs_pkg::*;

	logic [7:0] even_mem [EVEN_ROWS];
	logic [7:0] odd_mem  [ODD_ROWS];

	logic [ROW_W-1:0]  clr_row_q;
	opcode_t           op_q;
	logic [ADDR_W-1:0] pl_q;
	logic [7:0]        even_rd_s1;
	logic [7:0]        odd_rd_s1;

	logic              set_pending_q;
	logic [ADDR_W-1:0] latched_q;
	logic [CNT_W-1:0]  fetch_q;
	logic [CNT_W-1:0]  set_q;
	logic [CNT_W-1:0]  draw_q;
	logic [CNT_W-1:0]  misalign_q;
	logic              res_valid_q;
	logic              resp_q;
	logic [DATA_W-1:0] rdata_q;

	logic [ROW_W-1:0]  even_rrow;
	logic [ROW_W-1:0]  odd_rrow;
	logic              even_we;
	logic              odd_we;
	logic [ROW_W-1:0]  even_wrow;
	logic [ROW_W-1:0]  odd_wrow;
	logic [7:0]        even_wdata;
	logic [7:0]        odd_wdata;
	logic [ROW_W-1:0]  set_row;
	logic              set_wr;
	logic [DATA_W-1:0] fetch_data;

	assign sts.clear_last = (clr_row_q == ROW_W'(EVEN_ROWS - 1));
	assign sts.out_free   = !res_valid_q || result_ready;

	// an odd address starts in the odd bank, its second byte in the next even row
	assign odd_rrow  = beat_payload[ROW_W:1];
	assign even_rrow = beat_payload[ROW_W:1] + ROW_W'(beat_payload[0]);

	assign set_row = latched_q[ROW_W:1];
	assign set_wr  = cmd.commit && (op_q == OP_SET) && set_pending_q && pair_ok(latched_q);

	always_comb begin
		even_we    = 1'b0;
		odd_we     = 1'b0;
		even_wrow  = clr_row_q;
		odd_wrow   = clr_row_q;
		even_wdata = 8'({clr_row_q, 1'b0});
		odd_wdata  = 8'({clr_row_q, 1'b1});
		if (cmd.clear) begin
			even_we = 1'b1;
			odd_we  = ({1'b0, clr_row_q} < (ROW_W + 1)'(ODD_ROWS));
		end else if (set_wr) begin
			even_we = 1'b1;
			odd_we  = 1'b1;
			if (latched_q[0]) begin
				odd_wrow   = set_row;
				odd_wdata  = pl_q[7:0];
				even_wrow  = set_row + ROW_W'(1);
				even_wdata = pl_q[15:8];
			end else begin
				even_wrow  = set_row;
				even_wdata = pl_q[7:0];
				odd_wrow   = set_row;
				odd_wdata  = pl_q[15:8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (even_we) even_mem[even_wrow] <= even_wdata;
		if (cmd.take) even_rd_s1 <= even_mem[even_rrow];
	end

	always_ff @(posedge clk) begin
		if (odd_we) odd_mem[odd_wrow] <= odd_wdata;
		if (cmd.take) odd_rd_s1 <= odd_mem[odd_rrow];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q <= opcode_t'(beat_opcode);
			pl_q <= beat_payload;
		end
	end

	always_comb begin
		fetch_data = '0;
		if (pair_ok(pl_q)) begin
			fetch_data = pl_q[0] ? {even_rd_s1, odd_rd_s1} : {odd_rd_s1, even_rd_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q     <= '0;
			set_pending_q <= 1'b0;
			latched_q     <= '0;
			fetch_q       <= '0;
			set_q         <= '0;
			draw_q        <= '0;
			misalign_q    <= '0;
			res_valid_q   <= 1'b0;
			resp_q        <= 1'b0;
			rdata_q       <= '0;
		end else begin
			if (cmd.clear) clr_row_q <= clr_row_q + ROW_W'(1);
			if (cmd.commit) begin
				res_valid_q <= 1'b1;
				resp_q      <= (op_q == OP_FETCH);
				rdata_q     <= (op_q == OP_FETCH) ? fetch_data : '0;
				case (op_q)
					OP_NOP: begin
						set_pending_q <= 1'b0;
					end
					OP_FETCH: begin
						fetch_q       <= fetch_q + CNT_W'(1);
						set_pending_q <= 1'b0;
					end
					OP_SET: begin
						if (!set_pending_q) begin
							set_pending_q <= 1'b1;
							latched_q     <= pl_q;
							if (pl_q[0]) misalign_q <= misalign_q + CNT_W'(1);
						end else begin
							set_q         <= set_q + CNT_W'(1);
							set_pending_q <= 1'b0;
						end
					end
					default: begin
						draw_q        <= draw_q + CNT_W'(1);
						set_pending_q <= 1'b0;
					end
				endcase
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// counters change only on commit, which waits for the result register
	assign result_valid   = res_valid_q;
	assign response_valid = resp_q;
	assign read_data      = rdata_q;
	assign fetch_total    = fetch_q;
	assign set_total      = set_q;
	assign draw_total     = draw_q;
	assign misalign_total = misalign_q;

	`FBS_ASSERT_IMPLY(a_clear_quiet, clk, arst_n, cmd.clear, !res_valid_q && !set_pending_q && !cmd.take)
	`FBS_ASSERT_NEXT(a_commit_loads, clk, arst_n, cmd.commit, res_valid_q)
	`FBS_ASSERT_NEXT(a_fetch_count, clk, arst_n, cmd.commit && op_q == OP_FETCH, fetch_q == CNT_W'($past(fetch_q) + CNT_W'(1)))
	`FBS_ASSERT_NEXT(a_pair_broken, clk, arst_n, cmd.commit && op_q != OP_SET, !set_pending_q)

endmodule
